@@ hw/rtl/anud_pkg.sv @@
// Shared types and constants for the archive Unicode name decoder.
package anud_pkg;

    localparam int NAME_DEPTH_DEF = 512;

    // Result packing: up to four UTF-16 units per result.
    localparam int LANES   = 4;
    localparam int LANE_W  = 2;
    localparam int UNIT_W  = 16;
    localparam int COUNT_W = 3;
    localparam int RUN_W   = 8;

    localparam logic [RUN_W-1:0] RUN_BIAS    = 8'd2;
    localparam logic [2:0]       SLOT_RELOAD = 3'd4;

    localparam logic ACTION_PLAIN   = 1'b0;
    localparam logic ACTION_ENCODED = 1'b1;

    typedef enum logic [1:0] {
        MODE_LOW  = 2'd0,
        MODE_HIGH = 2'd1,
        MODE_WIDE = 2'd2,
        MODE_RUN  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_RUN_PAST  = 2'd1,
        ST_TRUNCATED = 2'd2
    } status_t;

    // Decoding phase of the current name.
    typedef enum logic [5:0] {
        PH_LOAD  = 6'b000001,
        PH_VAL   = 6'b000010,
        PH_HI16  = 6'b000100,
        PH_DELTA = 6'b001000,
        PH_DONE  = 6'b010000,
        PH_ERROR = 6'b100000
    } phase_t;

    // Request sequencer.
    typedef enum logic [3:0] {
        SEQ_IDLE    = 4'b0001,
        SEQ_RUN_RD  = 4'b0010,
        SEQ_RUN_ADD = 4'b0100,
        SEQ_PUSH    = 4'b1000
    } seq_t;

endpackage

@@ hw/rtl/anud_name_store.sv @@
// Plain name byte store: one write port, one registered read port.
module anud_name_store #(
    parameter int NAME_DEPTH = anud_pkg::NAME_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [$clog2(NAME_DEPTH)-1:0] wr_addr,
    input  logic [7:0]                    wr_data,
    input  logic                          rd_en,
    input  logic [$clog2(NAME_DEPTH)-1:0] rd_addr,
    output logic [7:0]                    rd_data
);

    logic [7:0] mem [NAME_DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/archive_unicode_name_decoder.sv @@
// Top level of the archive Unicode name decoder (packed UTF-16 file names).
//
// Usage:
//   Input channel (in_valid/in_ready): each request carries action, data_byte
//   and stream_end. Action plain loads one byte of the 8-bit name into the
//   store; a plain byte after any encoded byte starts a new name.
//   Action encoded feeds the packed stream: high byte, flag bytes, elements.
//   Output channel (out_valid/out_ready): results of up to four UTF-16 units,
//   with run_last, name_done and status on the last result of a request.
// Flow:
//   Plain bytes and bytes that give no result: accepted back to back.
//   Single-unit elements: accepted, then pushed into the output reg.
//   Runs: accepted, then per unit a store read and then the shared add
//   unit, and per result the check that closes it and then the push; the
//   store's single read port sets this pace. Longest run: 129 units in
//   33 results.
//   in_ready is low while a request is being expanded or pushed.
// Reset: control state and the output valid flag are cleared at once; the
//   name store is not cleared, as only entries below the loaded length are
//   ever read. No warm-up cycles.
// Stall: a full output register holds the sequencer in its push step until
//   the receiver takes the waiting result.
module archive_unicode_name_decoder #(
    parameter int NAME_DEPTH = anud_pkg::NAME_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic [7:0]  data_byte,
    input  logic        stream_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] unit_a,
    output logic [15:0] unit_b,
    output logic [15:0] unit_c,
    output logic [15:0] unit_d,
    output logic [2:0]  unit_count,
    output logic        run_last,
    output logic        name_done,
    output logic [1:0]  status
);

    localparam int AW = $clog2(NAME_DEPTH);
    localparam int LW = $clog2(NAME_DEPTH + 1);

    localparam int LANES   = anud_pkg::LANES;
    localparam int LANE_W  = anud_pkg::LANE_W;
    localparam int UNIT_W  = anud_pkg::UNIT_W;
    localparam int COUNT_W = anud_pkg::COUNT_W;
    localparam int RUN_W   = anud_pkg::RUN_W;

    // Sequencer and name state
    anud_pkg::seq_t    seq_reg, seq_next;
    anud_pkg::phase_t  phase_reg, phase_next;
    logic [LW-1:0]     plain_len_reg, plain_len_next;
    logic [LW-1:0]     out_idx_reg, out_idx_next;
    logic [7:0]        high_reg, high_next;
    logic [7:0]        mode_bits_reg, mode_bits_next;
    logic [2:0]        slot_reg, slot_next;
    logic [7:0]        held_reg, held_next;
    logic [7:0]        delta_reg, delta_next;
    logic              with_delta_reg, with_delta_next;
    logic              end_reg, end_next;
    logic [RUN_W-1:0]  run_left_reg, run_left_next;

    // Result being gathered
    logic [UNIT_W-1:0] pack_unit_reg [LANES];
    logic [UNIT_W-1:0] pack_unit_next [LANES];
    logic [COUNT_W-1:0] pack_cnt_reg, pack_cnt_next;
    logic              push_final_reg, push_final_next;
    logic              push_done_reg, push_done_next;
    anud_pkg::status_t push_status_reg, push_status_next;

    // Output register
    logic              out_valid_reg;
    logic [UNIT_W-1:0] out_unit_reg [LANES];
    logic [COUNT_W-1:0] out_count_reg;
    logic              out_last_reg;
    logic              out_done_reg;
    anud_pkg::status_t out_status_reg;
    logic              load_out;

    // Store port
    logic          store_wr_en;
    logic [AW-1:0] store_wr_addr;
    logic          store_rd_en;
    logic [7:0]    store_rd_data;

    // Decode helpers
    logic                in_acc;
    anud_pkg::mode_t     mode;
    logic [7:0]          unit_sum;
    logic [LANE_W-1:0]   pack_slot;
    logic                emit_single;
    logic [UNIT_W-1:0]   single_unit;
    logic                trunc;
    logic                start_run;
    logic [7:0]          run_lead;
    logic                finish_run;
    logic                run_err;

    anud_name_store #(
        .NAME_DEPTH (NAME_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (store_wr_en),
        .wr_addr (store_wr_addr),
        .wr_data (data_byte),
        .rd_en   (store_rd_en),
        .rd_addr (out_idx_reg[AW-1:0]),
        .rd_data (store_rd_data)
    );

    assign in_ready = (seq_reg == anud_pkg::SEQ_IDLE);
    assign in_acc   = in_valid && in_ready;

    // Flag byte modes are taken from the top bits down.
    always_comb
    begin
        case (slot_reg[1:0])
            2'd0:    mode = anud_pkg::mode_t'(mode_bits_reg[7:6]);
            2'd1:    mode = anud_pkg::mode_t'(mode_bits_reg[5:4]);
            2'd2:    mode = anud_pkg::mode_t'(mode_bits_reg[3:2]);
            default: mode = anud_pkg::mode_t'(mode_bits_reg[1:0]);
        endcase
    end

    // Shared adder: plain byte plus run delta.
    assign unit_sum  = store_rd_data + delta_reg;
    assign pack_slot = pack_cnt_reg[LANE_W-1:0];

    always_comb
    begin
        seq_next         = seq_reg;
        phase_next       = phase_reg;
        plain_len_next   = plain_len_reg;
        out_idx_next     = out_idx_reg;
        high_next        = high_reg;
        mode_bits_next   = mode_bits_reg;
        slot_next        = slot_reg;
        held_next        = held_reg;
        delta_next       = delta_reg;
        with_delta_next  = with_delta_reg;
        end_next         = end_reg;
        run_left_next    = run_left_reg;
        pack_unit_next   = pack_unit_reg;
        pack_cnt_next    = pack_cnt_reg;
        push_final_next  = push_final_reg;
        push_done_next   = push_done_reg;
        push_status_next = push_status_reg;
        store_wr_en      = 1'b0;
        store_wr_addr    = plain_len_reg[AW-1:0];
        store_rd_en      = 1'b0;
        load_out         = 1'b0;
        emit_single      = 1'b0;
        single_unit      = '0;
        trunc            = 1'b0;
        start_run        = 1'b0;
        run_lead         = data_byte;
        finish_run       = 1'b0;
        run_err          = 1'b0;

        case (seq_reg)
            anud_pkg::SEQ_IDLE:
            begin
                if (in_acc && action == anud_pkg::ACTION_PLAIN)
                begin
                    if (phase_reg != anud_pkg::PH_LOAD)
                    begin
                        // new name: drop the old one's state
                        phase_next     = anud_pkg::PH_LOAD;
                        out_idx_next   = '0;
                        high_next      = '0;
                        mode_bits_next = '0;
                        slot_next      = anud_pkg::SLOT_RELOAD;
                        held_next      = '0;
                        store_wr_en    = 1'b1;
                        store_wr_addr  = '0;
                        plain_len_next = LW'(1);
                    end
                    else if (plain_len_reg != LW'(NAME_DEPTH))
                    begin
                        store_wr_en    = 1'b1;
                        plain_len_next = plain_len_reg + LW'(1);
                    end
                end
                else if (in_acc)
                begin
                    pack_cnt_next = '0;
                    case (phase_reg)
                        anud_pkg::PH_LOAD:
                        begin
                            high_next    = data_byte;
                            slot_next    = anud_pkg::SLOT_RELOAD;
                            out_idx_next = '0;
                            if (stream_end)
                            begin
                                phase_next       = anud_pkg::PH_DONE;
                                push_final_next  = 1'b1;
                                push_done_next   = 1'b1;
                                push_status_next = anud_pkg::ST_OK;
                                seq_next         = anud_pkg::SEQ_PUSH;
                            end
                            else
                            begin
                                phase_next = anud_pkg::PH_VAL;
                            end
                        end
                        anud_pkg::PH_VAL:
                        begin
                            if (slot_reg[2])
                            begin
                                mode_bits_next = data_byte;
                                slot_next      = '0;
                                trunc          = stream_end;
                            end
                            else
                            begin
                                slot_next = slot_reg + 3'd1;
                                case (mode)
                                    anud_pkg::MODE_LOW:
                                    begin
                                        emit_single = 1'b1;
                                        single_unit = {8'h00, data_byte};
                                    end
                                    anud_pkg::MODE_HIGH:
                                    begin
                                        emit_single = 1'b1;
                                        single_unit = {high_reg, data_byte};
                                    end
                                    anud_pkg::MODE_WIDE:
                                    begin
                                        held_next  = data_byte;
                                        phase_next = anud_pkg::PH_HI16;
                                        trunc      = stream_end;
                                    end
                                    anud_pkg::MODE_RUN:
                                    begin
                                        if (data_byte[7])
                                        begin
                                            held_next  = data_byte;
                                            phase_next = anud_pkg::PH_DELTA;
                                            trunc      = stream_end;
                                        end
                                        else
                                        begin
                                            start_run       = 1'b1;
                                            delta_next      = '0;
                                            with_delta_next = 1'b0;
                                        end
                                    end
                                    default:
                                    begin
                                        emit_single = 1'b0;
                                    end
                                endcase
                            end
                        end
                        anud_pkg::PH_HI16:
                        begin
                            emit_single = 1'b1;
                            single_unit = {data_byte, held_reg};
                            phase_next  = anud_pkg::PH_VAL;
                        end
                        anud_pkg::PH_DELTA:
                        begin
                            start_run       = 1'b1;
                            run_lead        = held_reg;
                            delta_next      = data_byte;
                            with_delta_next = 1'b1;
                            phase_next      = anud_pkg::PH_VAL;
                        end
                        default:
                        begin
                            // name finished or failed: byte ignored
                            phase_next = phase_reg;
                        end
                    endcase

                    if (trunc)
                    begin
                        phase_next       = anud_pkg::PH_ERROR;
                        push_final_next  = 1'b1;
                        push_done_next   = 1'b0;
                        push_status_next = anud_pkg::ST_TRUNCATED;
                        seq_next         = anud_pkg::SEQ_PUSH;
                    end

                    if (emit_single)
                    begin
                        pack_unit_next[0] = single_unit;
                        pack_cnt_next     = COUNT_W'(1);
                        if (out_idx_reg != LW'(NAME_DEPTH))
                        begin
                            out_idx_next = out_idx_reg + LW'(1);
                        end
                        push_final_next  = 1'b1;
                        push_done_next   = stream_end;
                        push_status_next = anud_pkg::ST_OK;
                        if (stream_end)
                        begin
                            phase_next = anud_pkg::PH_DONE;
                        end
                        seq_next = anud_pkg::SEQ_PUSH;
                    end

                    if (start_run)
                    begin
                        run_left_next = RUN_W'(run_lead[6:0]) + anud_pkg::RUN_BIAS;
                        end_next      = stream_end;
                        seq_next      = anud_pkg::SEQ_RUN_RD;
                    end
                end
            end

            anud_pkg::SEQ_RUN_RD:
            begin
                if (run_left_reg == '0)
                begin
                    finish_run = 1'b1;
                end
                else if (out_idx_reg >= plain_len_reg)
                begin
                    finish_run = 1'b1;
                    run_err    = 1'b1;
                end
                else if (pack_cnt_reg == COUNT_W'(LANES))
                begin
                    // more units follow: this result is not the last
                    push_final_next  = 1'b0;
                    push_done_next   = 1'b0;
                    push_status_next = anud_pkg::ST_OK;
                    seq_next         = anud_pkg::SEQ_PUSH;
                end
                else
                begin
                    store_rd_en = 1'b1;
                    seq_next    = anud_pkg::SEQ_RUN_ADD;
                end

                if (finish_run)
                begin
                    push_final_next  = 1'b1;
                    push_done_next   = 1'b0;
                    push_status_next = anud_pkg::ST_OK;
                    seq_next         = anud_pkg::SEQ_PUSH;
                    if (run_err)
                    begin
                        phase_next       = anud_pkg::PH_ERROR;
                        push_status_next = anud_pkg::ST_RUN_PAST;
                    end
                    else if (end_reg)
                    begin
                        phase_next     = anud_pkg::PH_DONE;
                        push_done_next = 1'b1;
                    end
                    else if (pack_cnt_reg == '0)
                    begin
                        seq_next = anud_pkg::SEQ_IDLE;
                    end
                end
            end

            anud_pkg::SEQ_RUN_ADD:
            begin
                if (with_delta_reg)
                begin
                    pack_unit_next[pack_slot] = {high_reg, unit_sum};
                end
                else
                begin
                    pack_unit_next[pack_slot] = {8'h00, store_rd_data};
                end
                pack_cnt_next = pack_cnt_reg + COUNT_W'(1);
                out_idx_next  = out_idx_reg + LW'(1);
                run_left_next = run_left_reg - RUN_W'(1);
                seq_next      = anud_pkg::SEQ_RUN_RD;
            end

            anud_pkg::SEQ_PUSH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out      = 1'b1;
                    pack_cnt_next = '0;
                    seq_next      = push_final_reg ? anud_pkg::SEQ_IDLE : anud_pkg::SEQ_RUN_RD;
                end
            end

            default:
            begin
                seq_next = anud_pkg::SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg         <= anud_pkg::SEQ_IDLE;
            phase_reg       <= anud_pkg::PH_LOAD;
            plain_len_reg   <= '0;
            out_idx_reg     <= '0;
            high_reg        <= '0;
            mode_bits_reg   <= '0;
            slot_reg        <= anud_pkg::SLOT_RELOAD;
            held_reg        <= '0;
            delta_reg       <= '0;
            with_delta_reg  <= 1'b0;
            end_reg         <= 1'b0;
            run_left_reg    <= '0;
            pack_unit_reg   <= '{default: '0};
            pack_cnt_reg    <= '0;
            push_final_reg  <= 1'b0;
            push_done_reg   <= 1'b0;
            push_status_reg <= anud_pkg::ST_OK;
        end
        else
        begin
            seq_reg         <= seq_next;
            phase_reg       <= phase_next;
            plain_len_reg   <= plain_len_next;
            out_idx_reg     <= out_idx_next;
            high_reg        <= high_next;
            mode_bits_reg   <= mode_bits_next;
            slot_reg        <= slot_next;
            held_reg        <= held_next;
            delta_reg       <= delta_next;
            with_delta_reg  <= with_delta_next;
            end_reg         <= end_next;
            run_left_reg    <= run_left_next;
            pack_unit_reg   <= pack_unit_next;
            pack_cnt_reg    <= pack_cnt_next;
            push_final_reg  <= push_final_next;
            push_done_reg   <= push_done_next;
            push_status_reg <= push_status_next;
        end
    end

    // Output register: valid under reset, payload loaded on push.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                // units past the count read as zero
                out_unit_reg[i] <= (COUNT_W'(i) < pack_cnt_reg) ? pack_unit_reg[i] : '0;
            end
            out_count_reg  <= pack_cnt_reg;
            out_last_reg   <= push_final_reg;
            out_done_reg   <= push_done_reg;
            out_status_reg <= push_status_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign unit_a     = out_unit_reg[0];
    assign unit_b     = out_unit_reg[1];
    assign unit_c     = out_unit_reg[2];
    assign unit_d     = out_unit_reg[3];
    assign unit_count = out_count_reg;
    assign run_last   = out_last_reg;
    assign name_done  = out_done_reg;
    assign status     = out_status_reg;

endmodule

@@ hw/rtl/anud_checker.sv @@
// Port-level checks for the archive Unicode name decoder, bound to the top level.
module anud_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] unit_a,
    input logic [15:0] unit_b,
    input logic [15:0] unit_c,
    input logic [15:0] unit_d,
    input logic [2:0]  unit_count,
    input logic        run_last,
    input logic        name_done,
    input logic [1:0]  status
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(unit_a) && $stable(unit_count)
            && $stable(status))
        else $error("stalled result changed");

    // Only the last result of a request may be partly filled or carry flags.
    a_mid_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !run_last |-> unit_count == 3'd4 && !name_done
            && status == anud_pkg::ST_OK)
        else $error("non-final result not full or flagged");

    // Units past the count are zero.
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && unit_count != 3'd4 |-> unit_d == 16'h0000
            && (unit_count >= 3'd3 || unit_c == 16'h0000)
            && (unit_count >= 3'd2 || unit_b == 16'h0000)
            && (unit_count >= 3'd1 || unit_a == 16'h0000))
        else $error("unit beyond count not zero");

    // A clean finish never carries an error.
    a_done_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && name_done |-> status == anud_pkg::ST_OK && run_last)
        else $error("name_done with error status");

    // Count never exceeds the four lanes.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> unit_count <= 3'd4)
        else $error("unit_count out of range");

endmodule

bind archive_unicode_name_decoder anud_checker u_anud_checker (.*);

@@ bench/archive_unicode_name_decoder_test.sv @@
// Self-checking testbench for the archive Unicode name decoder.
module archive_unicode_name_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH         = anud_pkg::NAME_DEPTH_DEF;
    localparam int LANES         = anud_pkg::LANES;
    localparam int RANDOM_ITEMS  = 145;
    localparam int MID_DRAIN_AT  = 60;
    localparam int LATE_DRAIN_AT = 110;
    localparam int HOLD_AT       = 40;      // requests accepted before the long hold-off
    localparam int HOLD_CYCLES   = 300;
    localparam int TAIL_CYCLES   = 64;
    localparam int RUN_LIMIT     = 129;     // longest run: 7-bit length plus two
    localparam longint LIMIT_NS  = 5_000_000;

    // One request on the input channel, plus a flag that makes the sender
    // wait for every outstanding result before offering it.
    typedef struct {
        logic       act;
        logic [7:0] data;
        logic       fin;
        bit         drain;
    } name_req_t;

    // One packed result as it appears on the output channel.
    typedef struct packed {
        logic [15:0] ua;
        logic [15:0] ub;
        logic [15:0] uc;
        logic [15:0] ud;
        logic [2:0]  cnt;
        logic        last;
        logic        done;
        logic [1:0]  st;
    } unit_result_t;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_ready;
    logic        action     = 1'b0;
    logic [7:0]  data_byte  = 8'h00;
    logic        stream_end = 1'b0;
    logic        out_valid;
    logic        out_ready  = 1'b0;
    logic [15:0] unit_a;
    logic [15:0] unit_b;
    logic [15:0] unit_c;
    logic [15:0] unit_d;
    logic [2:0]  unit_count;
    logic        run_last;
    logic        name_done;
    logic [1:0]  status;

    archive_unicode_name_decoder uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .data_byte  (data_byte),
        .stream_end (stream_end),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .unit_a     (unit_a),
        .unit_b     (unit_b),
        .unit_c     (unit_c),
        .unit_d     (unit_d),
        .unit_count (unit_count),
        .run_last   (run_last),
        .name_done  (name_done),
        .status     (status)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Bench bookkeeping
    // ------------------------------------------------------------------
    name_req_t    request_q[$];         // requests still to be offered
    unit_result_t unit_results_due[$];  // predicted results, oldest first
    logic [15:0]  decoded_units[$];     // units produced by the current request

    int  total_n      = 0;
    int  accepted_n   = 0;              // updated with NBAs only
    int  random_count = 0;
    int  mismatch_n   = 0;
    bit  next_drain   = 1'b0;
    int  hold_left    = 0;
    bit  hold_used    = 1'b0;

    // ------------------------------------------------------------------
    // Decoder model state
    // ------------------------------------------------------------------
    logic [7:0]        nm_store [DEPTH];
    int                nm_len;
    int                nm_out;
    logic [7:0]        nm_high;
    logic [7:0]        nm_flags;
    int                nm_slot;
    anud_pkg::phase_t  nm_phase;
    logic [7:0]        nm_held;

    function automatic void clear_name_state();
        nm_len   = 0;
        nm_out   = 0;
        nm_high  = 8'h00;
        nm_flags = 8'h00;
        nm_slot  = 4;
        nm_held  = 8'h00;
        nm_phase = anud_pkg::PH_LOAD;
    endfunction

    // The output index saturates at the store depth.
    function automatic void add_unit(logic [15:0] u);
        decoded_units.push_back(u);
        if (nm_out < DEPTH)
        begin
            nm_out++;
        end
    endfunction

    // Copies plain-name bytes from the output index; 1 if it ran past the name.
    function automatic bit expand_run(logic [7:0] lead, logic [7:0] delta, bit add_delta);
        int n;
        int i;
        logic [7:0] p;
        n = int'(lead[6:0]) + 2;
        for (i = 0; i < n; i++)
        begin
            if (nm_out >= nm_len || nm_out >= DEPTH)
            begin
                return 1'b1;
            end
            p = nm_store[nm_out];
            if (add_delta)
            begin
                add_unit({nm_high, 8'(p + delta)});
            end
            else
            begin
                add_unit({8'h00, p});
            end
        end
        return 1'b0;
    endfunction

    // Splits the units of one request into results of up to four lanes.
    // Status and name_done ride on the last result only.
    function automatic void pack_units(anud_pkg::status_t st, logic done);
        unit_result_t r;
        logic [15:0]  lane [4];
        int i;
        int j;
        int k;
        i = 0;
        do
        begin
            k = decoded_units.size() - i;
            if (k > LANES)
            begin
                k = LANES;
            end
            for (j = 0; j < 4; j++)
            begin
                lane[j] = (j < k) ? decoded_units[i + j] : 16'h0000;
            end
            i += k;
            r.ua   = lane[0];
            r.ub   = lane[1];
            r.uc   = lane[2];
            r.ud   = lane[3];
            r.cnt  = 3'(k);
            r.last = (i >= decoded_units.size());
            r.done = r.last ? done : 1'b0;
            r.st   = r.last ? st : anud_pkg::ST_OK;
            unit_results_due.push_back(r);
        end
        while (i < decoded_units.size());
    endfunction

    function automatic void close_element(bit past, logic fin);
        if (past)
        begin
            nm_phase = anud_pkg::PH_ERROR;
            pack_units(anud_pkg::ST_RUN_PAST, 1'b0);
        end
        else if (fin)
        begin
            nm_phase = anud_pkg::PH_DONE;
            pack_units(anud_pkg::ST_OK, 1'b1);
        end
        else if (decoded_units.size() != 0)
        begin
            pack_units(anud_pkg::ST_OK, 1'b0);
        end
    endfunction

    // Advances the model by one accepted request and queues its results.
    function automatic void decode_request(logic act, logic [7:0] b, logic fin);
        anud_pkg::mode_t md;
        bit              past;
        past = 1'b0;
        decoded_units.delete();
        if (act == anud_pkg::ACTION_PLAIN)
        begin
            // a plain byte after any encoded byte starts a new name
            if (nm_phase != anud_pkg::PH_LOAD)
            begin
                clear_name_state();
            end
            if (nm_len < DEPTH)
            begin
                nm_store[nm_len] = b;
                nm_len++;
            end
            return;
        end
        case (nm_phase)
            anud_pkg::PH_LOAD:
            begin
                nm_high = b;
                nm_slot = 4;
                nm_out  = 0;
                if (fin)
                begin
                    nm_phase = anud_pkg::PH_DONE;
                    pack_units(anud_pkg::ST_OK, 1'b1);
                end
                else
                begin
                    nm_phase = anud_pkg::PH_VAL;
                end
            end
            anud_pkg::PH_VAL:
            begin
                if (nm_slot >= 4)
                begin
                    nm_flags = b;
                    nm_slot  = 0;
                    if (fin)
                    begin
                        nm_phase = anud_pkg::PH_ERROR;
                        pack_units(anud_pkg::ST_TRUNCATED, 1'b0);
                    end
                    return;
                end
                md = anud_pkg::mode_t'(nm_flags[7 - 2 * nm_slot -: 2]);
                nm_slot++;
                case (md)
                    anud_pkg::MODE_LOW:
                    begin
                        add_unit({8'h00, b});
                    end
                    anud_pkg::MODE_HIGH:
                    begin
                        add_unit({nm_high, b});
                    end
                    anud_pkg::MODE_WIDE:
                    begin
                        nm_held  = b;
                        nm_phase = anud_pkg::PH_HI16;
                    end
                    default:
                    begin
                        if (b[7])
                        begin
                            nm_held  = b;
                            nm_phase = anud_pkg::PH_DELTA;
                        end
                        else
                        begin
                            past = expand_run(b, 8'h00, 1'b0);
                        end
                    end
                endcase
                if (nm_phase != anud_pkg::PH_VAL)
                begin
                    if (fin)
                    begin
                        nm_phase = anud_pkg::PH_ERROR;
                        pack_units(anud_pkg::ST_TRUNCATED, 1'b0);
                    end
                    return;
                end
                close_element(past, fin);
            end
            anud_pkg::PH_HI16:
            begin
                add_unit({b, nm_held});
                nm_phase = anud_pkg::PH_VAL;
                close_element(1'b0, fin);
            end
            anud_pkg::PH_DELTA:
            begin
                past     = expand_run(nm_held, b, 1'b1);
                nm_phase = anud_pkg::PH_VAL;
                close_element(past, fin);
            end
            default:
            begin
                // done or failed: encoded bytes are ignored
                past = 1'b0;
            end
        endcase
    endfunction

    function automatic string fmt_result(unit_result_t r);
        return $sformatf("a=%h b=%h c=%h d=%h n=%0d last=%b done=%b st=%0d",
                         r.ua, r.ub, r.uc, r.ud, r.cnt, r.last, r.done, r.st);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------
    task automatic push_req(input logic act, input logic [7:0] b, input logic fin,
                            input bit counted = 1'b1);
        name_req_t r;
        r.act      = act;
        r.data     = b;
        r.fin      = fin;
        r.drain    = next_drain;
        next_drain = 1'b0;
        request_q.push_back(r);
        if (counted)
        begin
            random_count++;
        end
    endtask

    // A well-formed name with random content; now and then it breaks off
    // mid element or runs past the plain name.
    task automatic gen_name(input bit long_name);
        int plen;
        int outp;
        int nel;
        int slot;
        int len;
        int room;
        int k;
        logic [7:0] flags;
        logic [7:0] lead;
        bit last;
        bit broken;
        anud_pkg::mode_t md;
        plen = long_name ? $urandom_range(40, 20) : $urandom_range(12, 1);
        for (k = 0; k < plen; k++)
        begin
            push_req(anud_pkg::ACTION_PLAIN, 8'($urandom), $urandom_range(7, 0) == 0);
        end
        if ($urandom_range(15, 0) == 0)
        begin
            push_req(anud_pkg::ACTION_ENCODED, 8'($urandom), 1'b1);   // empty name
            return;
        end
        push_req(anud_pkg::ACTION_ENCODED, 8'($urandom), 1'b0);
        nel    = long_name ? $urandom_range(12, 4) : $urandom_range(8, 1);
        broken = ($urandom_range(7, 0) == 0);
        outp   = 0;
        slot   = 4;
        flags  = 8'h00;
        for (k = 0; k < nel; k++)
        begin
            last = (k == nel - 1);
            if (slot == 4)
            begin
                flags = 8'($urandom);
                slot  = 0;
                if (last && broken && $urandom_range(2, 0) == 0)
                begin
                    push_req(anud_pkg::ACTION_ENCODED, flags, 1'b1);
                    return;
                end
                push_req(anud_pkg::ACTION_ENCODED, flags, 1'b0);
            end
            md = anud_pkg::mode_t'(flags[7 - 2 * slot -: 2]);
            slot++;
            case (md)
                anud_pkg::MODE_LOW, anud_pkg::MODE_HIGH:
                begin
                    push_req(anud_pkg::ACTION_ENCODED, 8'($urandom), last);
                    outp++;
                end
                anud_pkg::MODE_WIDE:
                begin
                    if (last && broken)
                    begin
                        push_req(anud_pkg::ACTION_ENCODED, 8'($urandom), 1'b1);
                        return;
                    end
                    push_req(anud_pkg::ACTION_ENCODED, 8'($urandom), 1'b0);
                    push_req(anud_pkg::ACTION_ENCODED, 8'($urandom), last);
                    outp++;
                end
                default:
                begin
                    // mostly runs that fit, sometimes any length
                    room = plen - outp;
                    if (room >= 2 && $urandom_range(5, 0) != 0)
                    begin
                        len = $urandom_range((room > RUN_LIMIT) ? RUN_LIMIT : room, 2);
                    end
                    else
                    begin
                        len = $urandom_range(RUN_LIMIT, 2);
                    end
                    lead = {1'($urandom), 7'(len - 2)};
                    if (lead[7])
                    begin
                        if (last && broken)
                        begin
                            push_req(anud_pkg::ACTION_ENCODED, lead, 1'b1);
                            return;
                        end
                        push_req(anud_pkg::ACTION_ENCODED, lead, 1'b0);
                        push_req(anud_pkg::ACTION_ENCODED, 8'($urandom), last);
                    end
                    else
                    begin
                        push_req(anud_pkg::ACTION_ENCODED, lead, last);
                    end
                    outp += len;
                    if (outp > plen)
                    begin
                        return;   // name has failed, later bytes would be ignored
                    end
                end
            endcase
        end
        // trailing bytes after the end of a name are ignored by the block
        if ($urandom_range(4, 0) == 0)
        begin
            push_req(anud_pkg::ACTION_ENCODED, 8'($urandom), 1'($urandom));
        end
    endtask

    // Short plain name followed by raw noise on the encoded side.
    task automatic gen_noise_name();
        int k;
        int n;
        n = $urandom_range(8, 1);
        for (k = 0; k < n; k++)
        begin
            push_req(anud_pkg::ACTION_PLAIN, 8'($urandom), 1'($urandom));
        end
        for (k = 0; k < 8; k++)
        begin
            push_req(anud_pkg::ACTION_ENCODED, 8'($urandom), $urandom_range(3, 0) == 0);
        end
    endtask

    // ------------------------------------------------------------------
    // Idling profile: sender 35 / receiver 50, then swapped, then none
    // ------------------------------------------------------------------
    function automatic int idle_phase();
        return (total_n == 0) ? 2 : (accepted_n * 3) / total_n;
    endfunction

    function automatic int sender_idle_pct();
        case (idle_phase())
            0:       return 35;
            1:       return 50;
            default: return 0;
        endcase
    endfunction

    function automatic int receiver_idle_pct();
        case (idle_phase())
            0:       return 50;
            1:       return 35;
            default: return 0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers queued requests; a request, once offered, is held
    // until accepted. Prediction happens at the accepting edge.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : drive
        name_req_t nxt;
        bit        holding;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            action     <= anud_pkg::ACTION_PLAIN;
            data_byte  <= 8'h00;
            stream_end <= 1'b0;
        end
        else
        begin
            holding = in_valid && !in_ready;
            if (in_valid && in_ready)
            begin
                decode_request(action, data_byte, stream_end);
                accepted_n <= accepted_n + 1;
            end
            if (!holding)
            begin
                // a drain request waits until every result so far has come
                if (request_q.size() != 0
                    && !(request_q[0].drain && unit_results_due.size() != 0)
                    && !($urandom_range(99, 0) < sender_idle_pct()))
                begin
                    nxt        = request_q.pop_front();
                    in_valid   <= 1'b1;
                    action     <= nxt.act;
                    data_byte  <= nxt.data;
                    stream_end <= nxt.fin;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, once, so the output fills and input stalls.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_used <= 1'b0;
        end
        else if (!hold_used && accepted_n >= HOLD_AT)
        begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each accepted result against the oldest prediction
    // and drives out_ready.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : receive
        unit_result_t got;
        unit_result_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = '{unit_a, unit_b, unit_c, unit_d, unit_count, run_last,
                        name_done, status};
                if (unit_results_due.size() == 0)
                begin
                    if (mismatch_n < 10)
                    begin
                        $display("unexpected result: %s", fmt_result(got));
                    end
                    mismatch_n++;
                end
                else
                begin
                    want = unit_results_due.pop_front();
                    if (got !== want)
                    begin
                        if (mismatch_n < 10)
                        begin
                            $display("result mismatch at %0t", $realtime);
                            $display("  expected %s", fmt_result(want));
                            $display("  actual   %s", fmt_result(got));
                        end
                        mismatch_n++;
                    end
                end
            end
            if (hold_left != 0)
            begin
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= !($urandom_range(99, 0) < receiver_idle_pct());
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        bit mid_drain;
        bit late_drain;
        mid_drain  = 1'b0;
        late_drain = 1'b0;
        clear_name_state();

        // Directed: every mode, byte extremes, run copy of the plain name.
        push_req(anud_pkg::ACTION_PLAIN,   8'h00, 1'b0);
        push_req(anud_pkg::ACTION_PLAIN,   8'hff, 1'b1);
        push_req(anud_pkg::ACTION_ENCODED, 8'hff, 1'b0);      // high byte
        push_req(anud_pkg::ACTION_ENCODED, 8'he4, 1'b0);      // run, wide, high, low
        push_req(anud_pkg::ACTION_ENCODED, 8'h00, 1'b0);      // run of two, no delta
        push_req(anud_pkg::ACTION_ENCODED, 8'hff, 1'b0);
        push_req(anud_pkg::ACTION_ENCODED, 8'hff, 1'b0);
        push_req(anud_pkg::ACTION_ENCODED, 8'h00, 1'b0);
        push_req(anud_pkg::ACTION_ENCODED, 8'hff, 1'b1);
        // new name after a finished one; high byte only, empty and done
        push_req(anud_pkg::ACTION_PLAIN,   8'h80, 1'b0);
        push_req(anud_pkg::ACTION_PLAIN,   8'h7f, 1'b0);
        push_req(anud_pkg::ACTION_PLAIN,   8'h41, 1'b0);
        push_req(anud_pkg::ACTION_ENCODED, 8'h00, 1'b1);
        // delta run, then a run that crosses the end of the plain name,
        // then a byte after the failure that must be ignored
        push_req(anud_pkg::ACTION_PLAIN,   8'h10, 1'b0);
        push_req(anud_pkg::ACTION_PLAIN,   8'h20, 1'b0);
        push_req(anud_pkg::ACTION_PLAIN,   8'h30, 1'b0);
        push_req(anud_pkg::ACTION_ENCODED, 8'h12, 1'b0);
        push_req(anud_pkg::ACTION_ENCODED, 8'hf0, 1'b0);
        push_req(anud_pkg::ACTION_ENCODED, 8'h80, 1'b0);
        push_req(anud_pkg::ACTION_ENCODED, 8'hf0, 1'b0);
        push_req(anud_pkg::ACTION_ENCODED, 8'h00, 1'b0);
        push_req(anud_pkg::ACTION_ENCODED, 8'h99, 1'b0);
        // stream ending on a flag byte
        push_req(anud_pkg::ACTION_PLAIN,   8'h61, 1'b0);
        push_req(anud_pkg::ACTION_ENCODED, 8'h00, 1'b0);
        push_req(anud_pkg::ACTION_ENCODED, 8'h80, 1'b1);

        // Random names, with two drains along the way.
        random_count = 0;
        while (random_count < RANDOM_ITEMS)
        begin
            if (!mid_drain && random_count >= MID_DRAIN_AT)
            begin
                next_drain = 1'b1;
                mid_drain  = 1'b1;
            end
            if (!late_drain && random_count >= LATE_DRAIN_AT)
            begin
                next_drain = 1'b1;
                late_drain = 1'b1;
            end
            case ($urandom_range(9, 0))
                0:       gen_noise_name();
                1:       gen_name(1'b1);
                default: gen_name(1'b0);
            endcase
        end
        total_n = request_q.size();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_n < total_n)
        begin
            @(posedge clk);
        end
        while (unit_results_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_n == 0 && unit_results_due.size() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #(LIMIT_NS);
        $display("Test completed with failures");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/anud_pkg.sv
hw/rtl/anud_name_store.sv
hw/rtl/archive_unicode_name_decoder.sv
hw/rtl/anud_checker.sv
bench/archive_unicode_name_decoder_test.sv
